FILE: rtl/rdrs_pkg.sv
// shared types, constants and digit helpers for the decimal radix sort core
`timescale 1ns / 1ps

package rdrs_pkg;

   // batch capacity default and value format
   localparam int BATCH_SIZE_DEF = 16;
   localparam int VALUE_W        = 7;
   localparam int DIGIT_W        = 4;
   localparam int RADIX          = 10;

   localparam logic [VALUE_W-1:0] VALUE_MAX = 7'd99;
   localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

   // sequencer states
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SCATTER,
      ST_GATHER,
      ST_OUT_RD,
      ST_OUT_WAIT,
      ST_OUT_HOLD
   } state_type;

   // datapath status seen by the sequencer
   typedef struct packed {
      logic req_fire;
      logic req_last;
      logic scatter_done;
      logic gather_done;
      logic pass_tens;
      logic rsp_fire;
      logic rsp_final;
   } status_type;

   // phase flags driven by the sequencer
   typedef struct packed {
      logic load;
      logic scatter;
      logic gather;
      logic out_rd;
      logic out_wait;
      logic out_hold;
   } phase_type;

   // clamp a loaded value to the two-digit range
   function automatic logic [VALUE_W-1:0] sat_value(input logic [VALUE_W-1:0] v);
      return (v > VALUE_MAX) ? VALUE_MAX : v;
   endfunction

   // v / 10 as multiply by 205 / 2048, exact for 0..99
   function automatic logic [DIGIT_W-1:0] tens_digit(input logic [VALUE_W-1:0] v);
      logic [14:0] prod;
      prod = 15'(v) * 15'd205;
      return prod[14:11];
   endfunction

   // v mod 10 from the tens digit
   function automatic logic [DIGIT_W-1:0] ones_digit(input logic [VALUE_W-1:0] v);
      logic [DIGIT_W-1:0] t;
      logic [VALUE_W-1:0] tx10;
      logic [VALUE_W-1:0] r;
      t    = tens_digit(v);
      tx10 = VALUE_W'({t, 3'b000}) + VALUE_W'({t, 1'b0});
      r    = v - tx10;
      return r[DIGIT_W-1:0];
   endfunction

endpackage

FILE: rtl/two_digit_decimal_radix_sort_core.sv
// top level: batch store, bucket store, bucket fill counts and result register
`timescale 1ns / 1ps
// Loading takes one input per cycle. After the last input of a batch the sort runs two
// passes, each a scatter that reads the item ram into the bucket ram and a gather that
// reads the buckets back into the item ram in digit order; read-out follows.
// Each result passes through a ram read, a register load and a transfer, and the next
// ram read waits until the current result is taken.
// Synchronous reset clears the sequencer, counters and fill counts; ram contents are kept.

module two_digit_decimal_radix_sort_core #(
   parameter int BATCH_SIZE = rdrs_pkg::BATCH_SIZE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rdrs_pkg::VALUE_W-1:0]  req_value,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rdrs_pkg::VALUE_W-1:0]  rsp_sorted_value,
   output logic                          rsp_final_res
);

   localparam int CW       = $clog2(BATCH_SIZE + 1);
   localparam int IT_AW    = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1;
   localparam int BK_DEPTH = rdrs_pkg::RADIX * BATCH_SIZE;
   localparam int BK_AW    = (BK_DEPTH > 1) ? $clog2(BK_DEPTH) : 1;
   localparam logic [CW-1:0] BATCH_CNT = CW'(BATCH_SIZE);

   localparam int VW = rdrs_pkg::VALUE_W;
   localparam int DW = rdrs_pkg::DIGIT_W;

   rdrs_pkg::status_type status;
   rdrs_pkg::phase_type  ph;

   // control and counter registers
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] j_ff, j_in;
   logic [DW-1:0] bkt_ff, bkt_in;
   logic          pend_ff, pend_in;
   logic          pass_ff, pass_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] fill_ff [rdrs_pkg::RADIX];
   logic [CW-1:0] fill_in [rdrs_pkg::RADIX];

   // result register
   logic [VW-1:0] rsp_value_ff, rsp_value_in;
   logic          rsp_final_ff, rsp_final_in;

   // ram ports
   logic             it_wr_en, it_rd_en;
   logic [IT_AW-1:0] it_wr_addr, it_rd_addr;
   logic [VW-1:0]    it_wr_data, it_rd_data;
   logic             bk_wr_en, bk_rd_en;
   logic [BK_AW-1:0] bk_wr_addr, bk_rd_addr;
   logic [VW-1:0]    bk_rd_data;

   // handshake and phase status
   logic          req_fire, rsp_fire, room;
   logic          sc_issue, g_issue, bkt_live;
   logic          scatter_done, gather_done;
   logic [DW-1:0] digit, dsel, bsel;
   logic [CW-1:0] fill_cur, idx_plus;

   assign req_ready = ph.load;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   assign room      = (count_ff < BATCH_CNT);
   assign idx_plus  = idx_ff + CW'(1);

   // scatter: read items in order, write each to its digit bucket
   assign sc_issue     = ph.scatter && (idx_ff != count_ff);
   assign scatter_done = ph.scatter && (idx_ff == count_ff) && !pend_ff;
   assign digit = pass_ff ? rdrs_pkg::tens_digit(it_rd_data)
                          : rdrs_pkg::ones_digit(it_rd_data);
   assign dsel  = (digit > rdrs_pkg::DIGIT_MAX) ? rdrs_pkg::DIGIT_MAX : digit;

   // gather: walk buckets 0..9, each up to its fill count
   assign bkt_live    = (bkt_ff <= rdrs_pkg::DIGIT_MAX);
   assign bsel        = bkt_live ? bkt_ff : '0;
   assign fill_cur    = bkt_live ? fill_ff[bsel] : '0;
   assign g_issue     = ph.gather && bkt_live && (j_ff < fill_cur);
   assign gather_done = ph.gather && !bkt_live && !pend_ff;

   // item ram: loaded from input or gather, read by scatter or read-out
   assign it_wr_en   = (req_fire && room) || (ph.gather && pend_ff);
   assign it_wr_addr = ph.load ? count_ff[IT_AW-1:0] : pos_ff[IT_AW-1:0];
   assign it_wr_data = ph.load ? rdrs_pkg::sat_value(req_value) : bk_rd_data;
   assign it_rd_en   = sc_issue || ph.out_rd;
   assign it_rd_addr = idx_ff[IT_AW-1:0];

   // bucket ram: row per digit, BATCH_SIZE entries per row
   assign bk_wr_en   = ph.scatter && pend_ff;
   assign bk_wr_addr = BK_AW'(dsel) * BK_AW'(BATCH_SIZE) + BK_AW'(fill_ff[dsel]);
   assign bk_rd_en   = g_issue;
   assign bk_rd_addr = BK_AW'(bsel) * BK_AW'(BATCH_SIZE) + BK_AW'(j_ff);

   rdrs_ram #(
      .WIDTH (VW),
      .DEPTH (BATCH_SIZE)
   ) u_item_ram (
      .clock   (clock),
      .wr_en   (it_wr_en),
      .wr_addr (it_wr_addr),
      .wr_data (it_wr_data),
      .rd_en   (it_rd_en),
      .rd_addr (it_rd_addr),
      .rd_data (it_rd_data)
   );

   rdrs_ram #(
      .WIDTH (VW),
      .DEPTH (BK_DEPTH)
   ) u_bucket_ram (
      .clock   (clock),
      .wr_en   (bk_wr_en),
      .wr_addr (bk_wr_addr),
      .wr_data (it_rd_data),
      .rd_en   (bk_rd_en),
      .rd_addr (bk_rd_addr),
      .rd_data (bk_rd_data)
   );

   // sequencer
   always_comb begin
      status.req_fire     = req_fire;
      status.req_last     = req_last;
      status.scatter_done = scatter_done;
      status.gather_done  = gather_done;
      status.pass_tens    = pass_ff;
      status.rsp_fire     = rsp_fire;
      status.rsp_final    = rsp_final_ff;
   end

   rdrs_fsm u_fsm (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .phase  (ph)
   );

   // next values of counters and result register
   always_comb begin
      count_in     = count_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      j_in         = j_ff;
      bkt_in       = bkt_ff;
      pass_in      = pass_ff;
      pend_in      = sc_issue || g_issue;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_final_in = rsp_final_ff;
      fill_in      = fill_ff;

      // batch fill count
      if (req_fire && room) begin
         count_in = count_ff + CW'(1);
      end else if (rsp_fire && rsp_final_ff) begin
         count_in = '0;
      end

      // shared read index for scatter and read-out
      if (sc_issue) begin
         idx_in = idx_plus;
      end else if (scatter_done || (rsp_fire && rsp_final_ff)) begin
         idx_in = '0;
      end else if (rsp_fire) begin
         idx_in = idx_plus;
      end

      // bucket counts grow on scatter writes
      if (bk_wr_en) begin
         fill_in[dsel] = fill_ff[dsel] + CW'(1);
      end

      // gather walk and write-back position
      if (g_issue) begin
         j_in = j_ff + CW'(1);
      end else if (ph.gather && bkt_live) begin
         bkt_in = bkt_ff + DW'(1);
         j_in   = '0;
      end
      if (ph.gather && pend_ff) begin
         pos_in = pos_ff + CW'(1);
      end
      if (gather_done) begin
         bkt_in  = '0;
         j_in    = '0;
         pos_in  = '0;
         pass_in = !pass_ff;
         for (int b = 0; b < rdrs_pkg::RADIX; b++) begin
            fill_in[b] = '0;
         end
      end

      // result register
      if (ph.out_wait) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = it_rd_data;
         rsp_final_in = (idx_plus == count_ff);
      end else if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         pos_ff       <= '0;
         j_ff         <= '0;
         bkt_ff       <= '0;
         pend_ff      <= 1'b0;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int b = 0; b < rdrs_pkg::RADIX; b++) begin
            fill_ff[b] <= '0;
         end
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         pos_ff       <= pos_in;
         j_ff         <= j_in;
         bkt_ff       <= bkt_in;
         pend_ff      <= pend_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_final_ff <= rsp_final_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_final_res    = rsp_final_ff;

   // loading and read-out never overlap
   a_no_load_during_out: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input ready while a result is pending");

   // batch never grows past capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= BATCH_CNT)
      else $error("item count above batch capacity");

   // gather write-back stays inside the batch
   a_gather_pos: assert property (@(posedge clock) disable iff (reset)
      (ph.gather && pend_ff) |-> (pos_ff < count_ff))
      else $error("gather wrote beyond the batch");

   // final flag only on the last index of the batch
   a_final_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_final_ff) |-> (idx_plus == count_ff))
      else $error("final flag on a non-final result");

   // after the final transfer the block reloads with an empty batch
   a_reload: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_final_ff) |=> (req_ready && (count_ff == '0)))
      else $error("no return to loading after the final transfer");

   // result valid exactly while the read-out holds a result
   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff == ph.out_hold)
      else $error("result valid outside the hold phase");

endmodule

FILE: rtl/rdrs_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module rdrs_ram #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/rdrs_fsm.sv
// phase sequencer: load, two scatter/gather passes, read-out
`timescale 1ns / 1ps

module rdrs_fsm (
   input  logic                   clock,
   input  logic                   reset,
   input  rdrs_pkg::status_type   status,
   output rdrs_pkg::phase_type    phase
);

   rdrs_pkg::state_type state_ff;
   rdrs_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rdrs_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rdrs_pkg::ST_LOAD: begin
            if (status.req_fire && status.req_last) state_in = rdrs_pkg::ST_SCATTER;
         end
         rdrs_pkg::ST_SCATTER: begin
            if (status.scatter_done) state_in = rdrs_pkg::ST_GATHER;
         end
         rdrs_pkg::ST_GATHER: begin
            if (status.gather_done) begin
               state_in = status.pass_tens ? rdrs_pkg::ST_OUT_RD : rdrs_pkg::ST_SCATTER;
            end
         end
         rdrs_pkg::ST_OUT_RD: begin
            state_in = rdrs_pkg::ST_OUT_WAIT;
         end
         rdrs_pkg::ST_OUT_WAIT: begin
            state_in = rdrs_pkg::ST_OUT_HOLD;
         end
         rdrs_pkg::ST_OUT_HOLD: begin
            if (status.rsp_fire) begin
               state_in = status.rsp_final ? rdrs_pkg::ST_LOAD : rdrs_pkg::ST_OUT_RD;
            end
         end
         default: state_in = rdrs_pkg::ST_LOAD;
      endcase
   end

   // phase flags
   always_comb begin
      phase = '0;
      unique case (state_ff)
         rdrs_pkg::ST_LOAD:     phase.load     = 1'b1;
         rdrs_pkg::ST_SCATTER:  phase.scatter  = 1'b1;
         rdrs_pkg::ST_GATHER:   phase.gather   = 1'b1;
         rdrs_pkg::ST_OUT_RD:   phase.out_rd   = 1'b1;
         rdrs_pkg::ST_OUT_WAIT: phase.out_wait = 1'b1;
         rdrs_pkg::ST_OUT_HOLD: phase.out_hold = 1'b1;
         default:               phase          = '0;
      endcase
   end

endmodule

FILE: dv/tb_top.sv
// self-checking testbench for the two-digit decimal radix sort core
`timescale 1ns / 1ps

module tb_top;

   localparam int BATCH_CAP    = rdrs_pkg::BATCH_SIZE_DEF;
   localparam int VW           = rdrs_pkg::VALUE_W;
   localparam int IDLE_LIMIT   = 4000;
   localparam int STALL_CYCLES = 400;
   localparam int STALL_AT     = 150;
   localparam int TARGET_ITEMS = 360;
   localparam int DRAIN_CYCLES = 200;

   typedef struct packed {
      logic [VW-1:0] value;
      logic          last;
      logic          after_drain;
   } load_item_type;

   typedef struct packed {
      logic [VW-1:0] value;
      logic          final_flag;
   } sorted_entry_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic [VW-1:0] req_value = '0;
   logic          req_last = 1'b0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [VW-1:0] rsp_sorted_value;
   logic          rsp_final_res;

   load_item_type    pending_q[$];
   sorted_entry_type sorted_expect_q[$];
   logic [VW-1:0]    batch_q[$];
   logic [VW-1:0]    scratch_q[$];

   int               send_wait;
   int               recv_wait;
   int               recv_next;
   int               req_count;
   int               rsp_count;
   int               stall_left;
   bit               stall_used;
   int               idle_cycles;
   int               fail_count = 0;
   load_item_type    next_item;
   sorted_entry_type want;

   two_digit_decimal_radix_sort_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_final_res    (rsp_final_res)
   );

   // clock and reset
   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // one stable distribution pass over the batch, ones or tens digit
   task automatic bucket_pass(input bit by_tens);
      int d;
      int i;
      int dig;
      scratch_q.delete();
      for (d = 0; d < rdrs_pkg::RADIX; d++) begin
         for (i = 0; i < batch_q.size(); i++) begin
            dig = by_tens ? int'(batch_q[i]) / rdrs_pkg::RADIX
                          : int'(batch_q[i]) % rdrs_pkg::RADIX;
            if (dig == d) scratch_q.push_back(batch_q[i]);
         end
      end
      batch_q = scratch_q;
   endtask

   // load one value; on the closing value sort the batch and queue the results
   task automatic sort_predict(input logic [VW-1:0] v, input logic lst);
      logic [VW-1:0]    clamped;
      sorted_entry_type ent;
      int i;
      clamped = (v > rdrs_pkg::VALUE_MAX) ? rdrs_pkg::VALUE_MAX : v;
      if (batch_q.size() < BATCH_CAP) batch_q.push_back(clamped);
      if (lst) begin
         bucket_pass(1'b0);
         bucket_pass(1'b1);
         for (i = 0; i < batch_q.size(); i++) begin
            ent.value      = batch_q[i];
            ent.final_flag = (i == batch_q.size() - 1);
            sorted_expect_q.push_back(ent);
         end
         batch_q.delete();
      end
   endtask

   task automatic add_item(input logic [VW-1:0] v, input logic lst, input logic drain);
      load_item_type it;
      it.value       = v;
      it.last        = lst;
      it.after_drain = drain;
      pending_q.push_back(it);
   endtask

   // input driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_value <= '0;
         req_last  <= 1'b0;
         send_wait <= 0;
         req_count <= 0;
      end else begin
         if (req_valid && req_ready) begin
            sort_predict(req_value, req_last);
            req_count <= req_count + 1;
         end
         if (!req_valid || req_ready) begin
            if (send_wait > 0) begin
               send_wait <= send_wait - 1;
               req_valid <= 1'b0;
            end else if (pending_q.size() > 0 &&
                         (!pending_q[0].after_drain || sorted_expect_q.size() == 0)) begin
               next_item = pending_q.pop_front();
               req_valid <= 1'b1;
               req_value <= next_item.value;
               req_last  <= next_item.last;
               // every third stretch of items runs back to back
               send_wait <= (((req_count / 48) % 3) == 2) ? 0 : $urandom_range(0, 16);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // one long receiver hold-off so the core fills and stalls its input
   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
         stall_used <= 1'b0;
      end else if (!stall_used && req_count >= STALL_AT) begin
         stall_left <= STALL_CYCLES;
         stall_used <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end
   end

   // result monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait <= 0;
         rsp_count <= 0;
      end else begin
         recv_next = (recv_wait > 0) ? recv_wait - 1 : 0;
         if (rsp_valid && rsp_ready) begin
            rsp_count <= rsp_count + 1;
            if (sorted_expect_q.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result: value %0d final %0b",
                           rsp_sorted_value, rsp_final_res);
               fail_count++;
            end else begin
               want = sorted_expect_q.pop_front();
               if (rsp_sorted_value !== want.value || rsp_final_res !== want.final_flag) begin
                  if (fail_count < 10)
                     $display("mismatch at result %0d: expected %0d final %0b, got %0d %0b",
                              rsp_count, want.value, want.final_flag,
                              rsp_sorted_value, rsp_final_res);
                  fail_count++;
               end
            end
            recv_next = (((rsp_count / 40) % 3) == 2) ? 0 : $urandom_range(0, 16);
         end
         recv_wait <= recv_next;
         rsp_ready <= (recv_next == 0) && (stall_left == 0);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("two_digit_decimal_radix_sort_core test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // stimulus and end of run
   initial begin
      int i;
      int len;
      int total_items;
      bit drain;
      logic [VW-1:0] v;

      // single-item batches at both ends of the range
      add_item(7'd0, 1'b1, 1'b0);
      add_item(7'd99, 1'b1, 1'b1);
      // out-of-range values saturate
      add_item(7'd127, 1'b0, 1'b0);
      add_item(7'd100, 1'b0, 1'b0);
      add_item(7'd42, 1'b1, 1'b0);
      // full batch with repeats, then a closing value that is dropped
      add_item(7'd91, 1'b0, 1'b1);
      add_item(7'd19, 1'b0, 1'b0);
      add_item(7'd55, 1'b0, 1'b0);
      add_item(7'd5, 1'b0, 1'b0);
      add_item(7'd50, 1'b0, 1'b0);
      add_item(7'd55, 1'b0, 1'b0);
      add_item(7'd9, 1'b0, 1'b0);
      add_item(7'd90, 1'b0, 1'b0);
      add_item(7'd0, 1'b0, 1'b0);
      add_item(7'd99, 1'b0, 1'b0);
      add_item(7'd11, 1'b0, 1'b0);
      add_item(7'd10, 1'b0, 1'b0);
      add_item(7'd1, 1'b0, 1'b0);
      add_item(7'd55, 1'b0, 1'b0);
      add_item(7'd98, 1'b0, 1'b0);
      add_item(7'd89, 1'b0, 1'b0);
      add_item(7'd42, 1'b1, 1'b0);

      // random batches, a few oversized, some starting after a full drain
      while (pending_q.size() < TARGET_ITEMS) begin
         len   = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 16);
         drain = ($urandom_range(0, 5) == 0);
         for (i = 0; i < len; i++) begin
            v = ($urandom_range(0, 7) == 0) ? VW'($urandom_range(100, 127))
                                            : VW'($urandom_range(0, 99));
            add_item(v, (i == len - 1), drain && (i == 0));
         end
      end
      total_items = pending_q.size();

      // wait until every item has been taken, then for every result
      while (req_count != total_items) @(posedge clock);
      while (sorted_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && sorted_expect_q.size() == 0) begin
         $display("two_digit_decimal_radix_sort_core test passed");
      end else begin
         $display("two_digit_decimal_radix_sort_core test failed");
      end
      $finish;
   end

endmodule
